/* src/device_access_allow_filter_unit_defines.svh */
// Assertion macros used by the allow filter controller.
`ifndef DEVICE_ACCESS_ALLOW_FILTER_UNIT_DEFINES_SVH
`define DEVICE_ACCESS_ALLOW_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DAAF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allow filter check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DAAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allow filter check failed");

`endif

/* src/daaf_pkg.sv */
// Shared types and constants of the device access allow filter.
package daaf_pkg;

    localparam int DEF_MAX_ENTRIES = 16;

    localparam int TYPE_W   = 16;
    localparam int DEV_W    = 32;
    localparam int REQ_W    = 16;
    localparam int ACC_W    = 3;
    localparam int INDEX_W  = 4;

    localparam logic [TYPE_W-1:0] TYPE_BLOCK = 16'd1;
    localparam logic [TYPE_W-1:0] TYPE_CHAR  = 16'd2;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic write_entry;
        logic start_query;
        logic rd_issue;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last_slot;
        logic out_free;
    } dp_status_t;

endpackage

/* src/device_access_allow_filter_unit.sv */
// A query walks ST_SCAN, reading one table slot per cycle from the entry memory,
// then ST_FLUSH and ST_DONE, where the verdict is loaded into the output register
// once it is free; no new beat is taken until then. A write beat returns nothing.
// Input is taken again while a finished verdict still waits in the output register.
// Reset (rst_n low, asynchronous) clears all slot valid bits: an empty table
// denies every query. Entry contents are not reset.
module device_access_allow_filter_unit #(
    parameter int MAX_ENTRIES = daaf_pkg::DEF_MAX_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [daaf_pkg::INDEX_W-1:0]  entry_index,
    input  logic                         entry_valid,
    input  logic                         entry_is_block,
    input  logic                         entry_minor_any,
    input  logic [daaf_pkg::ACC_W-1:0]    entry_allowed,
    input  logic [daaf_pkg::TYPE_W-1:0]   dev_kind,
    input  logic [daaf_pkg::DEV_W-1:0]    dev_major,
    input  logic [daaf_pkg::DEV_W-1:0]    dev_minor,
    input  logic [daaf_pkg::REQ_W-1:0]    access_request,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         allow
);
    import daaf_pkg::*;

    // Command and status between the sequencer and the table datapath.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: take a beat in idle; a write is stored straight from idle, a query
    // walks every slot, drains the compare stage, then waits for the
    // output register to free up.
    daaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: slot memory with registered read, per-slot valid bits,
    // held query fields, match compare and the verdict output register.
    daaf_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .entry_index     (entry_index),
        .entry_valid     (entry_valid),
        .entry_is_block  (entry_is_block),
        .entry_minor_any (entry_minor_any),
        .entry_allowed   (entry_allowed),
        .dev_kind        (dev_kind),
        .dev_major       (dev_major),
        .dev_minor       (dev_minor),
        .access_request  (access_request),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .allow           (allow)
    );

endmodule

/* src/daaf_ctrl.sv */
// Controller state machine: accept beats, sequence the table scan, hand off the verdict.
`include "device_access_allow_filter_unit_defines.svh"

module daaf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  daaf_pkg::dp_status_t status,
    output daaf_pkg::ctrl_cmd_t  cmd
);
    import daaf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cmd_t'(command) == CMD_WRITE)
                    begin
                        cmd.write_entry = 1'b1;
                    end
                    else
                    begin
                        cmd.start_query = 1'b1;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (status.last_slot)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `DAAF_ASSERT_NEXT(a_query_starts_scan, in_valid && in_ready && command == CMD_QUERY, state_reg == ST_SCAN)
    `DAAF_ASSERT_NEXT(a_last_slot_flushes, state_reg == ST_SCAN && status.last_slot, state_reg == ST_FLUSH)
    `DAAF_ASSERT_NEXT(a_done_returns_idle, state_reg == ST_DONE && status.out_free, state_reg == ST_IDLE)
    `DAAF_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.write_entry, cmd.start_query, cmd.rd_issue, cmd.load_out}))

endmodule

/* src/daaf_datapath.sv */
// Datapath: entry table, query registers, slot compare and verdict register.
module daaf_datapath #(
    parameter int MAX_ENTRIES = daaf_pkg::DEF_MAX_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  daaf_pkg::ctrl_cmd_t               cmd,
    output daaf_pkg::dp_status_t              status,
    input  logic [daaf_pkg::INDEX_W-1:0]      entry_index,
    input  logic                             entry_valid,
    input  logic                             entry_is_block,
    input  logic                             entry_minor_any,
    input  logic [daaf_pkg::ACC_W-1:0]        entry_allowed,
    input  logic [daaf_pkg::TYPE_W-1:0]       dev_kind,
    input  logic [daaf_pkg::DEV_W-1:0]        dev_major,
    input  logic [daaf_pkg::DEV_W-1:0]        dev_minor,
    input  logic [daaf_pkg::REQ_W-1:0]        access_request,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             allow
);
    import daaf_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_ENTRIES - 1);

    // Entry storage, no reset: a slot is only trusted while its valid bit is set.
    logic [DEV_W-1:0] major_mem [MAX_ENTRIES];
    logic [DEV_W-1:0] minor_mem [MAX_ENTRIES];
    logic             block_mem [MAX_ENTRIES];
    logic             any_mem   [MAX_ENTRIES];
    logic [ACC_W-1:0] acc_mem   [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] slot_valid_reg;

    logic [AW-1:0]     cnt_reg;
    logic              cmp_vld_reg;
    logic              rd_valid_reg;
    logic [DEV_W-1:0]  rd_major_reg;
    logic [DEV_W-1:0]  rd_minor_reg;
    logic              rd_block_reg;
    logic              rd_any_reg;
    logic [ACC_W-1:0]  rd_acc_reg;

    logic [TYPE_W-1:0] q_type_reg;
    logic [DEV_W-1:0]  q_major_reg;
    logic [DEV_W-1:0]  q_minor_reg;
    logic [ACC_W-1:0]  q_req_reg;

    logic hit_reg;
    logic out_valid_reg;
    logic allow_reg;

    logic              wr_in_range;
    logic [AW-1:0]     wr_addr;
    logic [TYPE_W-1:0] want_type;
    logic              slot_match;

    assign wr_in_range = 32'(entry_index) < MAX_ENTRIES;
    assign wr_addr     = AW'(entry_index);

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && wr_in_range && entry_valid)
        begin
            major_mem[wr_addr] <= dev_major;
            minor_mem[wr_addr] <= dev_minor;
            block_mem[wr_addr] <= entry_is_block;
            any_mem[wr_addr]   <= entry_minor_any;
            acc_mem[wr_addr]   <= entry_allowed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_major_reg <= major_mem[cnt_reg];
            rd_minor_reg <= minor_mem[cnt_reg];
            rd_block_reg <= block_mem[cnt_reg];
            rd_any_reg   <= any_mem[cnt_reg];
            rd_acc_reg   <= acc_mem[cnt_reg];
        end
        if (cmd.start_query)
        begin
            q_type_reg  <= dev_kind;
            q_major_reg <= dev_major;
            q_minor_reg <= dev_minor;
            q_req_reg   <= access_request[ACC_W-1:0];
        end
        if (cmd.load_out)
        begin
            allow_reg <= hit_reg;
        end
    end

    assign want_type  = rd_block_reg ? TYPE_BLOCK : TYPE_CHAR;
    assign slot_match = rd_valid_reg
                     && (q_type_reg == want_type)
                     && (q_major_reg == rd_major_reg)
                     && (rd_any_reg || (q_minor_reg == rd_minor_reg))
                     && ((q_req_reg & ~rd_acc_reg) == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write_entry && wr_in_range)
            begin
                slot_valid_reg[wr_addr] <= entry_valid;
            end
            cmp_vld_reg <= cmd.rd_issue;
            if (cmd.rd_issue)
            begin
                rd_valid_reg <= slot_valid_reg[cnt_reg];
            end
            if (cmd.start_query)
            begin
                cnt_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (cmd.rd_issue)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (cmp_vld_reg && slot_match)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.last_slot = (cnt_reg == LAST_SLOT);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign allow     = allow_reg;

endmodule
